>>> src/chtd_pkg.sv
`timescale 1ns / 1ps

package chtd_pkg;

    // Table geometry
    localparam int CLUSTER_INDEX_BITS = 10;
    localparam int WAYS_PER_CLUSTER   = 4;
    localparam int NUM_CLUSTERS       = 1 << CLUSTER_INDEX_BITS;
    localparam int WAY_BITS           = (WAYS_PER_CLUSTER > 1) ? $clog2(WAYS_PER_CLUSTER) : 1;

    // Command codes
    localparam logic [1:0] CMD_PROBE = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Input word
    typedef struct packed {
        logic [1:0]         cmd;
        logic [63:0]        position_key;
        logic [6:0]         search_depth;
        logic signed [15:0] eval_score;
        logic [1:0]         bound_kind;
        logic [15:0]        move_word;
    } t_in;

    // Result word
    typedef struct packed {
        logic               hit;
        logic               written;
        logic signed [7:0]  found_depth;
        logic signed [15:0] found_score;
        logic [1:0]         found_bound;
        logic [15:0]        found_move;
    } t_out;

    // One stored way
    typedef struct packed {
        logic [63:0]        tag;
        logic signed [7:0]  depth;
        logic signed [15:0] score;
        logic [1:0]         bound;
        logic [15:0]        move;
    } t_way;

    // One cluster, a single memory row
    typedef t_way [WAYS_PER_CLUSTER-1:0] t_row;

    // Write-back decision from the lookup logic
    typedef struct packed {
        logic                write;
        logic [WAY_BITS-1:0] way;
    } t_dec;

    localparam t_way WAY_EMPTY = '{tag: 64'd0, depth: -8'sd1, score: 16'sd0,
                                   bound: 2'd0, move: 16'd0};
    localparam t_row ROW_EMPTY = t_row'({WAYS_PER_CLUSTER{WAY_EMPTY}});

    // Result of anything that is not a hit
    localparam t_out OUT_NONE = '{hit: 1'b0, written: 1'b0, found_depth: -8'sd1,
                                  found_score: 16'sd0, found_bound: 2'd0,
                                  found_move: 16'd0};

endpackage

>>> src/clustered_hash_table_depth_replace_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports                    Handshake
// command   in         i_word (t_in)            start && !busy
// result    out        o_word (t_out)           o_strobe, one cycle
//
// Probe, store and unused commands: one cluster read from the
// table RAM, then compare, decide and write back in the next cycle; the
// result strobes in the cycle after that, where a new word is already taken.
// Clear sweeps the RAM one cluster per cycle, busy throughout; its result
// strobes in the first sweep cycle.
// Reset runs the same clearing pass before the first word.
// The receiver cannot stall; results are never held.

module clustered_hash_table_depth_replace_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  chtd_pkg::t_in  i_word,
    output logic           o_strobe,
    output chtd_pkg::t_out o_word
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    t_state                                  r_state;
    logic [chtd_pkg::CLUSTER_INDEX_BITS-1:0] r_addr;
    chtd_pkg::t_in                           r_item;
    logic                                    r_strobe;
    chtd_pkg::t_out                          r_word;

    logic                                    ram_we;
    logic [chtd_pkg::CLUSTER_INDEX_BITS-1:0] ram_waddr;
    chtd_pkg::t_row                          ram_wdata;
    chtd_pkg::t_row                          ram_rdata;
    chtd_pkg::t_row                          n_row;
    chtd_pkg::t_way                          n_way;
    chtd_pkg::t_dec                          dec;
    chtd_pkg::t_out                          lk_word;
    logic                                    accept;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // Cluster storage, one row per cluster
    chtd_ram #(
        .WIDTH ($bits(chtd_pkg::t_row)),
        .DEPTH (chtd_pkg::NUM_CLUSTERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_word.position_key[chtd_pkg::CLUSTER_INDEX_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    chtd_lookup u_lookup (
        .i_row  (ram_rdata),
        .i_item (r_item),
        .o_dec  (dec),
        .o_word (lk_word)
    );

    // Modified row for write-back
    always_comb begin
        n_way = '{tag: r_item.position_key,
                  depth: signed'({1'b0, r_item.search_depth}),
                  score: r_item.eval_score,
                  bound: r_item.bound_kind,
                  move: r_item.move_word};
        n_row = ram_rdata;
        n_row[dec.way] = n_way;
    end

    // Write port: clearing sweep or lookup write-back
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_item.position_key[chtd_pkg::CLUSTER_INDEX_BITS-1:0];
        ram_wdata = n_row;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = chtd_pkg::ROW_EMPTY;
            end
            ST_LOOKUP: begin
                ram_we = dec.write;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_addr   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    r_addr <= r_addr + chtd_pkg::CLUSTER_INDEX_BITS'(1);
                    if (&r_addr) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_item <= i_word;
                        if (i_word.cmd == chtd_pkg::CMD_CLEAR) begin
                            r_state  <= ST_CLEAR;
                            r_addr   <= '0;
                            r_strobe <= 1'b1;
                            r_word   <= chtd_pkg::OUT_NONE;
                        end else begin
                            r_state <= ST_LOOKUP;
                        end
                    end
                end
                ST_LOOKUP: begin
                    r_strobe <= 1'b1;
                    r_word   <= lk_word;
                    r_state  <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_word   = r_word;

endmodule

>>> src/chtd_ram.sv
`timescale 1ns / 1ps

module chtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/chtd_lookup.sv
`timescale 1ns / 1ps

module chtd_lookup (
    input  chtd_pkg::t_row i_row,
    input  chtd_pkg::t_in  i_item,
    output chtd_pkg::t_dec o_dec,
    output chtd_pkg::t_out o_word
);

    logic                          found;
    logic                          stop;
    logic                          same;
    logic                          skip;
    logic                          chosen;
    logic [chtd_pkg::WAY_BITS-1:0] pick;
    logic signed [7:0]             lowest;
    logic signed [7:0]             new_depth;

    assign new_depth = signed'({1'b0, i_item.search_depth});

    // Probe: first matching way with non-negative depth
    // Store: same-tag way first, else first way of lowest depth
    always_comb begin
        found  = 1'b0;
        stop   = 1'b0;
        same   = 1'b0;
        skip   = 1'b0;
        chosen = 1'b0;
        pick   = '0;
        lowest = '0;
        o_word = chtd_pkg::OUT_NONE;
        o_dec  = '0;

        for (int w = 0; w < chtd_pkg::WAYS_PER_CLUSTER; w++) begin
            if (!found && i_row[w].tag == i_item.position_key && !i_row[w].depth[7]) begin
                found = 1'b1;
                o_word.hit         = 1'b1;
                o_word.found_depth = i_row[w].depth;
                o_word.found_score = i_row[w].score;
                o_word.found_bound = i_row[w].bound;
                o_word.found_move  = i_row[w].move;
            end
            if (!stop) begin
                if (i_row[w].tag == i_item.position_key) begin
                    // deeper same-tag entry blocks the write
                    if (i_row[w].depth > new_depth) begin
                        skip = 1'b1;
                    end else begin
                        pick = chtd_pkg::WAY_BITS'(w);
                        same = 1'b1;
                    end
                    stop = 1'b1;
                end else if (!chosen || i_row[w].depth < lowest) begin
                    lowest = i_row[w].depth;
                    pick   = chtd_pkg::WAY_BITS'(w);
                    chosen = 1'b1;
                end
            end
        end

        // replacement victim deeper than the new result
        if (!same && !skip && i_row[pick].depth > new_depth) begin
            skip = 1'b1;
        end

        case (i_item.cmd)
            chtd_pkg::CMD_PROBE: begin
                o_dec = '0;
            end
            chtd_pkg::CMD_STORE: begin
                o_word        = chtd_pkg::OUT_NONE;
                o_word.written = !skip;
                o_dec.write   = !skip;
                o_dec.way     = pick;
            end
            default: begin
                o_word = chtd_pkg::OUT_NONE;
                o_dec  = '0;
            end
        endcase
    end

endmodule

>>> src/chtd_checker.sv
`timescale 1ns / 1ps

module chtd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input chtd_pkg::t_in  i_word,
    input logic           o_strobe,
    input chtd_pkg::t_out o_word
);

    // Table lookups answer after the cluster read and the lookup state that follow the accept
    a_lookup_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_word.cmd != chtd_pkg::CMD_CLEAR) |-> ##2 o_strobe)
        else $error("lookup result missing two cycles after accept");

    // Clear answers as the sweep begins and keeps the block busy for the sweep
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_word.cmd == chtd_pkg::CMD_CLEAR) |=> (o_strobe && busy))
        else $error("clear did not answer or did not stay busy");

    // One word in flight at a time
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("word accepted while previous one in flight");

    // A hit carries a valid depth and never reports a write
    a_hit_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.hit) |-> (!o_word.found_depth[7] && !o_word.written))
        else $error("hit with negative depth or written flag");

    // Only a clear taken right behind a result answers in the adjacent cycle
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !(start && !busy && i_word.cmd == chtd_pkg::CMD_CLEAR))
        |=> !o_strobe)
        else $error("two results in adjacent cycles");

endmodule

bind clustered_hash_table_depth_replace_core chtd_checker u_chtd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_word   (i_word),
    .o_strobe (o_strobe),
    .o_word   (o_word)
);

>>> verif/clustered_hash_table_depth_replace_core_test.sv
`timescale 1ns / 1ps

module clustered_hash_table_depth_replace_core_test;

    localparam int          NUM_ENTRIES  = chtd_pkg::NUM_CLUSTERS * chtd_pkg::WAYS_PER_CLUSTER;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam int          RANDOM_ITEMS = 2000;
    localparam int          DRAIN_CYCLES = 8;
    // a clear sweep or the reset pass is the longest quiet stretch
    localparam int          IDLE_LIMIT   = 5000;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    logic           busy;
    chtd_pkg::t_in  i_word  = '0;
    logic           o_strobe;
    chtd_pkg::t_out o_word;

    int gap_max     = 12;
    int idle_cycles = 0;

    // Shadow copy of the table plus the results still owed by the block
    class table_shadow;
        logic [63:0]        tag_mem   [NUM_ENTRIES];
        logic signed [7:0]  depth_mem [NUM_ENTRIES];
        logic signed [15:0] score_mem [NUM_ENTRIES];
        logic [1:0]         bound_mem [NUM_ENTRIES];
        logic [15:0]        move_mem  [NUM_ENTRIES];
        chtd_pkg::t_out     owed_results [$];
        int                 mismatches;

        function new();
            mismatches = 0;
            wipe_table();
        endfunction

        function void wipe_table();
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                tag_mem[e]   = '0;
                depth_mem[e] = -8'sd1;
                score_mem[e] = '0;
                bound_mem[e] = '0;
                move_mem[e]  = '0;
            end
        endfunction

        // Probe / store / clear against the shadow table (other commands leave it alone), returns the result word
        function chtd_pkg::t_out lookup_or_store(chtd_pkg::t_in w);
            chtd_pkg::t_out r;
            int   base;
            int   pick;
            int   lowest;
            int   e;
            int   new_depth;
            bit   chosen;
            bit   same;
            bit   skip;
            r = '{hit: 1'b0, written: 1'b0, found_depth: -8'sd1, found_score: 16'sd0,
                  found_bound: 2'd0, found_move: 16'd0};
            base      = int'(w.position_key[chtd_pkg::CLUSTER_INDEX_BITS-1:0])
                        * chtd_pkg::WAYS_PER_CLUSTER;
            new_depth = int'(w.search_depth);
            pick      = base;
            lowest    = 0;
            chosen    = 1'b0;
            same      = 1'b0;
            skip      = 1'b0;
            case (w.cmd)
                chtd_pkg::CMD_PROBE: begin
                    // first way with equal tag and a valid depth
                    for (int k = 0; k < chtd_pkg::WAYS_PER_CLUSTER; k++) begin
                        e = base + k;
                        if (tag_mem[e] == w.position_key && depth_mem[e] >= 0) begin
                            r.hit         = 1'b1;
                            r.found_depth = depth_mem[e];
                            r.found_score = score_mem[e];
                            r.found_bound = bound_mem[e];
                            r.found_move  = move_mem[e];
                            break;
                        end
                    end
                end
                chtd_pkg::CMD_STORE: begin
                    // same tag wins unless deeper; else first way of lowest depth
                    for (int k = 0; k < chtd_pkg::WAYS_PER_CLUSTER; k++) begin
                        e = base + k;
                        if (tag_mem[e] == w.position_key) begin
                            if (int'(depth_mem[e]) > new_depth) begin
                                skip = 1'b1;
                            end else begin
                                pick = e;
                                same = 1'b1;
                            end
                            break;
                        end
                        if (!chosen || int'(depth_mem[e]) < lowest) begin
                            lowest = int'(depth_mem[e]);
                            pick   = e;
                            chosen = 1'b1;
                        end
                    end
                    if (!skip && (same || int'(depth_mem[pick]) <= new_depth)) begin
                        tag_mem[pick]   = w.position_key;
                        depth_mem[pick] = 8'(new_depth);
                        score_mem[pick] = w.eval_score;
                        bound_mem[pick] = w.bound_kind;
                        move_mem[pick]  = w.move_word;
                        r.written       = 1'b1;
                    end
                end
                chtd_pkg::CMD_CLEAR: begin
                    wipe_table();
                end
                default: begin
                end
            endcase
            return r;
        endfunction

        function void note_command(chtd_pkg::t_in w);
            owed_results.push_back(lookup_or_store(w));
        endfunction

        function void check_result(chtd_pkg::t_out r);
            chtd_pkg::t_out exp_r;
            if (owed_results.size() == 0) begin
                $error("result word with nothing outstanding: %h", r);
                mismatches++;
                return;
            end
            exp_r = owed_results.pop_front();
            if (r.hit !== exp_r.hit) begin
                $error("hit: expected %0d, got %0d", exp_r.hit, r.hit);
                mismatches++;
            end
            if (r.written !== exp_r.written) begin
                $error("written: expected %0d, got %0d", exp_r.written, r.written);
                mismatches++;
            end
            if (r.found_depth !== exp_r.found_depth) begin
                $error("found_depth: expected %0d, got %0d", exp_r.found_depth, r.found_depth);
                mismatches++;
            end
            if (r.found_score !== exp_r.found_score) begin
                $error("found_score: expected %0d, got %0d", exp_r.found_score, r.found_score);
                mismatches++;
            end
            if (r.found_bound !== exp_r.found_bound) begin
                $error("found_bound: expected %0d, got %0d", exp_r.found_bound, r.found_bound);
                mismatches++;
            end
            if (r.found_move !== exp_r.found_move) begin
                $error("found_move: expected %h, got %h", exp_r.found_move, r.found_move);
                mismatches++;
            end
        endfunction
    endclass

    table_shadow tt = new();

    clustered_hash_table_depth_replace_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_word   (i_word),
        .o_strobe (o_strobe),
        .o_word   (o_word)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Words accepted and results strobed, both sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                tt.check_result(o_word);
            end
            if (start && !busy) begin
                tt.note_command(i_word);
            end
        end
    end

    // Watchdog: cycles with no traffic in either direction
    always @(posedge i_clk) begin
        if (i_rst_n && ((start && !busy) || o_strobe)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [63:0] make_key(logic [63:0] upper, int cluster);
        return (upper << chtd_pkg::CLUSTER_INDEX_BITS) | 64'(cluster);
    endfunction

    // Hold start high until the block takes the word; random gap ahead of it
    task automatic send_word(chtd_pkg::t_in w);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic issue(logic [1:0] cmd, logic [63:0] key, int depth, int score,
                         int bound, int move);
        chtd_pkg::t_in w;
        w.cmd          = cmd;
        w.position_key = key;
        w.search_depth = 7'(depth);
        w.eval_score   = 16'(score);
        w.bound_kind   = 2'(bound);
        w.move_word    = 16'(move);
        send_word(w);
    endtask

    // Most keys come from a few clusters and tags so ways collide and get evicted
    function automatic chtd_pkg::t_in random_word();
        chtd_pkg::t_in w;
        int            roll;
        logic [63:0]   uppers [5];
        int            clusters [5];
        uppers   = '{64'd0, '1, 64'd1, 64'h2B5_A3C1, 64'h1_F00D};
        clusters = '{0, 1, chtd_pkg::NUM_CLUSTERS - 1, chtd_pkg::NUM_CLUSTERS / 2,
                     77 % chtd_pkg::NUM_CLUSTERS};
        roll = $urandom_range(0, 199);
        if (roll < 2) begin
            w.cmd = chtd_pkg::CMD_CLEAR;
        end else if (roll < 12) begin
            w.cmd = CMD_UNUSED;
        end else if (roll < 100) begin
            w.cmd = chtd_pkg::CMD_PROBE;
        end else begin
            w.cmd = chtd_pkg::CMD_STORE;
        end
        if ($urandom_range(0, 4) == 0) begin
            w.position_key = {$urandom, $urandom};
        end else begin
            w.position_key = make_key(uppers[$urandom_range(0, 4)],
                                      clusters[$urandom_range(0, 4)]);
        end
        if ($urandom_range(0, 9) < 7) begin
            w.search_depth = 7'($urandom_range(0, 15));
        end else begin
            w.search_depth = 7'($urandom_range(0, 127));
        end
        w.eval_score = 16'($urandom);
        w.bound_kind = 2'($urandom_range(0, 3));
        w.move_word  = 16'($urandom);
        return w;
    endfunction

    initial begin
        logic [63:0]   key_a;
        logic [63:0]   key_b;
        logic [63:0]   key_c;
        logic [63:0]   key_d;
        chtd_pkg::t_in w;
        int            n_items;
        int            draws;

        key_a = make_key(64'h1234, chtd_pkg::NUM_CLUSTERS - 1);
        key_b = make_key(64'h0BAD, chtd_pkg::NUM_CLUSTERS - 1);
        key_c = make_key(64'h7777, chtd_pkg::NUM_CLUSTERS - 1);
        key_d = make_key(64'h0042, chtd_pkg::NUM_CLUSTERS - 1);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // key zero: cleared way never hits on probe, but a store claims it
        issue(chtd_pkg::CMD_PROBE, 64'd0, 0, 0, 0, 0);
        issue(chtd_pkg::CMD_STORE, 64'd0, 0, 100, 2, 16'h1234);
        issue(chtd_pkg::CMD_PROBE, 64'd0, 0, 0, 0, 0);
        issue(chtd_pkg::CMD_STORE, 64'd0, 0, -32768, 3, 16'hFFFF);
        issue(chtd_pkg::CMD_PROBE, 64'd0, 0, 0, 0, 0);
        // all-ones key at full depth, then a shallower same-tag store is refused
        issue(chtd_pkg::CMD_STORE, '1, 127, 32767, 1, 0);
        issue(chtd_pkg::CMD_PROBE, '1, 0, 0, 0, 0);
        issue(chtd_pkg::CMD_STORE, '1, 5, -1, 0, 16'hAAAA);
        issue(chtd_pkg::CMD_PROBE, '1, 0, 0, 0, 0);
        // fill the last cluster, then replacement by lowest depth
        issue(chtd_pkg::CMD_STORE, key_a, 10, 11, 1, 16'h0101);
        issue(chtd_pkg::CMD_STORE, key_b, 3, 22, 2, 16'h0202);
        issue(chtd_pkg::CMD_STORE, key_c, 50, 33, 3, 16'h0303);
        issue(chtd_pkg::CMD_STORE, key_d, 2, 44, 1, 16'h0404);
        issue(chtd_pkg::CMD_PROBE, key_d, 0, 0, 0, 0);
        issue(chtd_pkg::CMD_STORE, key_d, 3, 55, 2, 16'h0505);
        issue(chtd_pkg::CMD_PROBE, key_d, 0, 0, 0, 0);
        issue(chtd_pkg::CMD_PROBE, key_b, 0, 0, 0, 0);
        issue(chtd_pkg::CMD_PROBE, key_a, 0, 0, 0, 0);
        // unused command leaves the table alone
        issue(CMD_UNUSED, key_a, 127, -32768, 3, 16'hFFFF);
        issue(chtd_pkg::CMD_PROBE, key_a, 0, 0, 0, 0);
        // clear empties everything
        issue(chtd_pkg::CMD_CLEAR, 64'd0, 0, 0, 0, 0);
        issue(chtd_pkg::CMD_PROBE, '1, 0, 0, 0, 0);
        issue(chtd_pkg::CMD_PROBE, 64'd0, 0, 0, 0, 0);

        // random phase, idling switched off in some stretches
        n_items = 0;
        draws   = 0;
        while (n_items < RANDOM_ITEMS) begin
            if (draws % 64 == 0) begin
                gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            end
            w = random_word();
            send_word(w);
            draws++;
            if (w.cmd != CMD_UNUSED) begin
                n_items++;
            end
        end
        start <= 1'b0;

        while (tt.owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tt.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
